// ----- rtl/core/pfc_pkg.sv -----
// Shared types, constants and the bytewise CRC-32 step for the PDU frame checker.
// Self-contained; used by every module of the checker.
`default_nettype none

package pfc_pkg;

  // Header layout, little-endian, byte offsets from frame start.
  localparam int unsigned HDR_LEN   = 20;
  localparam int unsigned VER_OFF   = 2;
  localparam int unsigned TYPE_OFF  = 3;
  localparam int unsigned FLAGS_OFF = 4;
  localparam int unsigned SLOT_OFF  = 6;
  localparam int unsigned RNTI_OFF  = 10;
  localparam int unsigned PRE_OFF   = 12;
  localparam int unsigned LEN_OFF   = 14;
  localparam int unsigned CRC_OFF   = 16;

  localparam int unsigned COUNT_W = 17;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] CRC_INIT = 32'hffff_ffff;

  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [15:0] MAGIC_RST   = 16'h0000;
  localparam logic [7:0]  VERSION_RST = 8'h01;
  localparam logic [63:0] TMASK_RST   = 64'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC     = 2'd0,
    CFG_VERSION   = 2'd1,
    CFG_TYPE_MASK = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_SHORT   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_TYPE    = 3'd4,
    ST_LENGTH  = 3'd5,
    ST_CRC     = 3'd6
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  pdu_type;
    logic [15:0] flag_bits;
    logic [31:0] slot_no;
    logic [15:0] rnti;
    logic [7:0]  preamble_code;
    logic [15:0] pld_length;
    logic [31:0] crc_value;
  } out_item_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [63:0] type_mask;
  } cfg_t;

  // Frame state as it stands once the byte now being processed is included.
  typedef struct packed {
    logic [HDR_LEN-1:0][7:0] hdr;
    logic [COUNT_W-1:0]      count;
    logic [31:0]             crc;
  } frame_view_t;

  typedef struct packed {
    logic step;  // the input stage hands its byte on this cycle
    logic last;  // that byte closes the frame
  } trk_ctl_t;

  // One byte of the reflected CRC-32: eight shift-and-conditional-xor steps.
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (r[0] ? CRC_POLY : 32'd0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfc_cfg_regs.sv -----
// Configuration registers of the PDU frame checker: magic, version and type mask.
// Depends on pfc_pkg.
`default_nettype none

module pfc_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pfc_pkg::cfg_t                       cfg_o
);

  pfc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        pfc_pkg::CFG_MAGIC:     cfg_d.magic     = cfg_data_i[15:0];
        pfc_pkg::CFG_VERSION:   cfg_d.version   = cfg_data_i[7:0];
        pfc_pkg::CFG_TYPE_MASK: cfg_d.type_mask = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic     <= pfc_pkg::MAGIC_RST;
      cfg_q.version   <= pfc_pkg::VERSION_RST;
      cfg_q.type_mask <= pfc_pkg::TMASK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/core/pfc_frame_track.sv -----
// Input register and running frame state: byte count, CRC-32 and header capture.
// Depends on pfc_pkg.
`default_nettype none

module pfc_frame_track (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire pfc_pkg::in_item_t  in_data_i,
  input  wire logic               hold_i,
  output pfc_pkg::trk_ctl_t       ctl_o,
  output pfc_pkg::frame_view_t    view_o
);

  logic                           s1_valid_q, s1_valid_d;
  pfc_pkg::in_item_t              s1_item_q;
  logic [pfc_pkg::COUNT_W-1:0]    count_q, count_d, count_next;
  logic [31:0]                    crc_q, crc_d, crc_next;
  logic [7:0]                     hdr_q [pfc_pkg::HDR_LEN];
  logic                           s1_adv;
  logic                           in_fire;
  logic                           in_hdr;
  logic                           crc_on;

  // A closing byte waits only while the result register is still occupied.
  assign s1_adv     = s1_valid_q && !(s1_item_q.last && hold_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  assign in_hdr = count_q < pfc_pkg::COUNT_W'(pfc_pkg::HDR_LEN);
  // The CRC field itself is left out of the checksum.
  assign crc_on = (count_q < pfc_pkg::COUNT_W'(pfc_pkg::CRC_OFF)) || !in_hdr;

  assign crc_next   = crc_on ? pfc_pkg::crc_byte(crc_q, s1_item_q.data_byte) : crc_q;
  assign count_next = (count_q == pfc_pkg::COUNT_MAX) ? count_q
                                                      : count_q + pfc_pkg::COUNT_W'(1);

  always_comb begin
    count_d = count_q;
    crc_d   = crc_q;
    if (s1_adv) begin
      if (s1_item_q.last) begin
        count_d = '0;
        crc_d   = pfc_pkg::CRC_INIT;
      end else begin
        count_d = count_next;
        crc_d   = crc_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      count_q    <= '0;
      crc_q      <= pfc_pkg::CRC_INIT;
    end else begin
      s1_valid_q <= s1_valid_d;
      count_q    <= count_d;
      crc_q      <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < pfc_pkg::HDR_LEN; k++) begin
      if (s1_adv && (count_q == pfc_pkg::COUNT_W'(k))) begin
        hdr_q[k] <= s1_item_q.data_byte;
      end
    end
  end

  always_comb begin
    view_o.count = count_next;
    view_o.crc   = crc_next;
    for (int k = 0; k < pfc_pkg::HDR_LEN; k++) begin
      view_o.hdr[k] = (count_q == pfc_pkg::COUNT_W'(k)) ? s1_item_q.data_byte : hdr_q[k];
    end
  end

  assign ctl_o.step = s1_adv;
  assign ctl_o.last = s1_item_q.last;

endmodule

`default_nettype wire

// ----- rtl/core/pfc_result_stage.sv -----
// Status evaluation for a closed frame and the result output register.
// Depends on pfc_pkg.
`default_nettype none

module pfc_result_stage (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pfc_pkg::cfg_t         cfg_i,
  input  wire pfc_pkg::trk_ctl_t     ctl_i,
  input  wire pfc_pkg::frame_view_t  view_i,
  output logic                       hold_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output pfc_pkg::out_item_t         out_data_o
);

  logic               out_valid_q, out_valid_d;
  pfc_pkg::out_item_t res_q, res_d;
  logic               load;
  logic [15:0]        magic;
  logic [7:0]         version;
  logic [7:0]         ptype;
  logic [15:0]        plen;
  logic [31:0]        rx_crc;
  logic               type_bad;
  logic               len_bad;
  logic               crc_bad;
  pfc_pkg::status_e   status;

  assign hold_o = out_valid_q && !out_ready_i;
  assign load   = ctl_i.step && ctl_i.last;

  assign magic   = {view_i.hdr[1], view_i.hdr[0]};
  assign version = view_i.hdr[pfc_pkg::VER_OFF];
  assign ptype   = view_i.hdr[pfc_pkg::TYPE_OFF];
  assign plen    = {view_i.hdr[pfc_pkg::LEN_OFF+1], view_i.hdr[pfc_pkg::LEN_OFF]};
  assign rx_crc  = {view_i.hdr[pfc_pkg::CRC_OFF+3], view_i.hdr[pfc_pkg::CRC_OFF+2],
                    view_i.hdr[pfc_pkg::CRC_OFF+1], view_i.hdr[pfc_pkg::CRC_OFF]};

  // Type codes of 64 and above are never valid.
  assign type_bad = (ptype[7:6] != 2'b00) || !cfg_i.type_mask[ptype[5:0]];
  assign len_bad  = view_i.count
                    != (pfc_pkg::COUNT_W'(pfc_pkg::HDR_LEN) + {1'b0, plen});
  assign crc_bad  = ~view_i.crc != rx_crc;

  always_comb begin
    if (view_i.count < pfc_pkg::COUNT_W'(pfc_pkg::HDR_LEN)) begin
      status = pfc_pkg::ST_SHORT;
    end else if (magic != cfg_i.magic) begin
      status = pfc_pkg::ST_MAGIC;
    end else if (version != cfg_i.version) begin
      status = pfc_pkg::ST_VERSION;
    end else if (type_bad) begin
      status = pfc_pkg::ST_TYPE;
    end else if (len_bad) begin
      status = pfc_pkg::ST_LENGTH;
    end else if (crc_bad) begin
      status = pfc_pkg::ST_CRC;
    end else begin
      status = pfc_pkg::ST_OK;
    end
  end

  always_comb begin
    res_d        = '0;
    res_d.status = status;
    if (status == pfc_pkg::ST_OK) begin
      res_d.pdu_type      = ptype;
      res_d.flag_bits     = {view_i.hdr[pfc_pkg::FLAGS_OFF+1], view_i.hdr[pfc_pkg::FLAGS_OFF]};
      res_d.slot_no       = {view_i.hdr[pfc_pkg::SLOT_OFF+3], view_i.hdr[pfc_pkg::SLOT_OFF+2],
                             view_i.hdr[pfc_pkg::SLOT_OFF+1], view_i.hdr[pfc_pkg::SLOT_OFF]};
      res_d.rnti          = {view_i.hdr[pfc_pkg::RNTI_OFF+1], view_i.hdr[pfc_pkg::RNTI_OFF]};
      res_d.preamble_code = view_i.hdr[pfc_pkg::PRE_OFF];
      res_d.pld_length    = plen;
      res_d.crc_value     = rx_crc;
    end
  end

  assign out_valid_d = load || hold_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

endmodule

`default_nettype wire

// ----- rtl/core/pdu_frame_checker_unit.sv -----
// PDU frame checker top level: wires the configuration registers, frame tracker
// and result stage together. Depends on pfc_pkg, pfc_cfg_regs, pfc_frame_track
// and pfc_result_stage.
// A request is registered on acceptance; the result for a frame is registered
// once its closing byte leaves the input register, which that byte does not do
// while the output register holds an unread result. Bytes are taken one per
// cycle, but for those stalls, set by the input register and the CRC byte step.
// Reset (asynchronous, active low) clears the pipeline valids, byte count and
// CRC and restores the configuration defaults; header bytes are not reset.
`default_nettype none

module pdu_frame_checker_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Configuration write port; index 3 is ignored.
  input  wire logic                           cfg_we_i,
  input  wire logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Byte requests in.
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire pfc_pkg::in_item_t              in_data_i,
  // Frame results out, one per closing byte.
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output pfc_pkg::out_item_t                  out_data_o
);

  pfc_pkg::cfg_t        cfg;
  pfc_pkg::trk_ctl_t    trk_ctl;
  pfc_pkg::frame_view_t view;
  logic                 hold;

  // Configuration must only be changed by the user while the checker is idle; the
  // block does not enforce this, and the status logic reads the registers directly.
  pfc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The input register accepts a new request every cycle. Non-closing bytes
  // always move on, since they produce no result; a closing byte stalls only
  // while the previous result still sits unread in the output register.
  pfc_frame_track u_frame_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .hold_i     (hold),
    .ctl_o      (trk_ctl),
    .view_o     (view)
  );

  // The result stage evaluates the checks in priority order on the frame view
  // that already includes the closing byte, and registers the result.
  pfc_result_stage u_result_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctl_i       (trk_ctl),
    .view_i      (view),
    .hold_o      (hold),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/core/pfc_checker.sv -----
// Port-level assertions for the PDU frame checker, bound to its top level.
// Depends on pfc_pkg and pdu_frame_checker_unit.
`default_nettype none

module pfc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire pfc_pkg::in_item_t   in_data_i,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire pfc_pkg::out_item_t  out_data_o
);

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // With the output register empty nothing can block the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  // A fresh result comes from a closing byte passed on from the input register.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o && in_data_i.last, 2))
    else $error("result without a closing byte");

  // Header fields are cleared on every failed frame.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != pfc_pkg::ST_OK) |->
      (out_data_o.pdu_type == 8'd0) && (out_data_o.flag_bits == 16'd0) &&
      (out_data_o.slot_no == 32'd0) && (out_data_o.rnti == 16'd0) &&
      (out_data_o.preamble_code == 8'd0) && (out_data_o.pld_length == 16'd0) &&
      (out_data_o.crc_value == 32'd0))
    else $error("header fields set on a failed frame");

endmodule

bind pdu_frame_checker_unit pfc_checker u_pfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// ----- test/pdu_frame_checker_unit_test.sv -----
// Self-checking testbench for pdu_frame_checker_unit: frames of PDU bytes in, one check result
// per frame out, predicted by a bytewise scoreboard. Depends on pfc_pkg and the checker RTL.
`timescale 1ns / 100ps

module pdu_frame_checker_unit_test;
  import pfc_pkg::*;

  // Type codes at or above this value are rejected whatever the mask holds.
  localparam int unsigned TYPE_CODES = 64;
  // The write port has one index that selects no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SEGMENTS = 8;
  localparam int ITEMS_PER_SEGMENT = 195;

  typedef enum int {
    FR_GOOD,
    FR_SHORT,
    FR_MAGIC,
    FR_VERSION,
    FR_TYPE,
    FR_LENGTH,
    FR_CRC,
    FR_NOISE
  } frame_kind_e;

  // Tracks the frame in progress byte by byte and holds the results it predicts.
  class pdu_result_board;
    logic [15:0] magic;
    logic [7:0] version;
    logic [63:0] type_mask;
    logic [COUNT_W-1:0] count;
    logic [31:0] crc;
    logic [7:0] hdr [HDR_LEN];
    out_item_t pending[$];
    int unsigned errors;

    function new();
      magic = MAGIC_RST;
      version = VERSION_RST;
      type_mask = TMASK_RST;
      count = '0;
      crc = CRC_INIT;
      errors = 0;
    endfunction

    // Reflected CRC-32, one input bit at a time.
    static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int k = 0; k < 8; k++) begin
        r = (r[0] ^ b[k]) ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_MAGIC: magic = data[15:0];
        CFG_VERSION: version = data[7:0];
        CFG_TYPE_MASK: type_mask = data;
        default: ;
      endcase
    endfunction

    function void note_byte(in_item_t it);
      out_item_t r;
      logic [7:0] ty;
      logic [15:0] plen;
      logic [31:0] rx;
      if (count < HDR_LEN) hdr[count[4:0]] = it.data_byte;
      if (count < CRC_OFF || count >= HDR_LEN) crc = crc_step(crc, it.data_byte);
      if (count != COUNT_MAX) count = count + 1'b1;
      if (!it.last) return;
      r = '0;
      if (count < HDR_LEN) begin
        r.status = ST_SHORT;
      end else begin
        ty = hdr[TYPE_OFF];
        plen = {hdr[LEN_OFF + 1], hdr[LEN_OFF]};
        rx = {hdr[CRC_OFF + 3], hdr[CRC_OFF + 2], hdr[CRC_OFF + 1], hdr[CRC_OFF]};
        if ({hdr[1], hdr[0]} != magic) r.status = ST_MAGIC;
        else if (hdr[VER_OFF] != version) r.status = ST_VERSION;
        else if (ty >= TYPE_CODES || !type_mask[ty[5:0]]) r.status = ST_TYPE;
        else if (count != HDR_LEN + plen) r.status = ST_LENGTH;
        else if (~crc != rx) r.status = ST_CRC;
        if (r.status == ST_OK) begin
          r.pdu_type = ty;
          r.flag_bits = {hdr[FLAGS_OFF + 1], hdr[FLAGS_OFF]};
          r.slot_no = {hdr[SLOT_OFF + 3], hdr[SLOT_OFF + 2], hdr[SLOT_OFF + 1], hdr[SLOT_OFF]};
          r.rnti = {hdr[RNTI_OFF + 1], hdr[RNTI_OFF]};
          r.preamble_code = hdr[PRE_OFF];
          r.pld_length = plen;
          r.crc_value = rx;
        end
      end
      pending.push_back(r);
      count = '0;
      crc = CRC_INIT;
    endfunction

    task report(string msg);
      $display("frame result mismatch: %s", msg);
      errors++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        report("result arrived with no frame outstanding");
      end else begin
        want = pending.pop_front();
        check_field("status", 32'(got.status), 32'(want.status));
        check_field("pdu_type", 32'(got.pdu_type), 32'(want.pdu_type));
        check_field("flag_bits", 32'(got.flag_bits), 32'(want.flag_bits));
        check_field("slot_no", got.slot_no, want.slot_no);
        check_field("rnti", 32'(got.rnti), 32'(want.rnti));
        check_field("preamble_code", 32'(got.preamble_code), 32'(want.preamble_code));
        check_field("pld_length", 32'(got.pld_length), 32'(want.pld_length));
        check_field("crc_value", got.crc_value, want.crc_value);
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_data_o;

  pdu_result_board board;
  logic [7:0] frame_bytes[$];
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  pdu_frame_checker_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Result side: every accepted result is checked against the oldest prediction. The same
  // block drives the random ready stalls and runs the watchdog, which trips when neither
  // channel has moved a request for too long.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
      $display("pdu_frame_checker_unit_test: errors");
      $finish;
    end else begin
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Presents one byte request, after a random idle gap, and holds it until it is taken.
  // The scoreboard is updated here, in the same process, so a drain never misses the
  // prediction for the byte that was just accepted.
  task automatic send_byte(input in_item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_byte(it);
  endtask

  task automatic send_frame();
    in_item_t it;
    foreach (frame_bytes[i]) begin
      it.data_byte = frame_bytes[i];
      it.last = (i == frame_bytes.size() - 1);
      send_byte(it);
    end
    items_sent += frame_bytes.size();
  endtask

  // Lets the checker go idle: no request in flight, every result delivered, and then a wait
  // so that nothing is left inside the pipeline.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, data);
  endtask

  // Builds a frame whose header passes the checks given the arguments, with a correct CRC
  // over header bytes 0-15 and the body. The length field and the body length are separate
  // so that a frame can disagree with its own header.
  task automatic build_frame(input logic [15:0] mg, input logic [7:0] ver, input logic [7:0] ty,
                             input logic [15:0] len_field, input int body_len,
                             input bit use_fill, input logic [7:0] fill);
    logic [31:0] c;
    frame_bytes.delete();
    frame_bytes.push_back(mg[7:0]);
    frame_bytes.push_back(mg[15:8]);
    frame_bytes.push_back(ver);
    frame_bytes.push_back(ty);
    for (int i = FLAGS_OFF; i < LEN_OFF; i++) begin
      frame_bytes.push_back(use_fill ? fill : 8'($urandom));
    end
    frame_bytes.push_back(len_field[7:0]);
    frame_bytes.push_back(len_field[15:8]);
    repeat (4) frame_bytes.push_back(8'h00);
    for (int i = 0; i < body_len; i++) frame_bytes.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (frame_bytes[i]) begin
      if (i < CRC_OFF || i >= HDR_LEN) c = pdu_result_board::crc_step(c, frame_bytes[i]);
    end
    c = ~c;
    for (int k = 0; k < 4; k++) frame_bytes[CRC_OFF + k] = c[8 * k +: 8];
  endtask

  function automatic logic [7:0] pick_valid_type();
    int t;
    if (board.type_mask == '0) return 8'($urandom_range(TYPE_CODES - 1));
    do t = $urandom_range(TYPE_CODES - 1); while (!board.type_mask[t]);
    return 8'(t);
  endfunction

  function automatic logic [7:0] pick_invalid_type();
    int t;
    if (board.type_mask == '1 || $urandom_range(1) == 0) begin
      return 8'($urandom_range(255, TYPE_CODES));
    end
    do t = $urandom_range(TYPE_CODES - 1); while (board.type_mask[t]);
    return 8'(t);
  endfunction

  function automatic frame_kind_e pick_kind();
    int p;
    p = $urandom_range(99);
    if (p < 60) return FR_GOOD;
    if (p < 65) return FR_SHORT;
    if (p < 70) return FR_MAGIC;
    if (p < 75) return FR_VERSION;
    if (p < 82) return FR_TYPE;
    if (p < 90) return FR_LENGTH;
    if (p < 95) return FR_CRC;
    return FR_NOISE;
  endfunction

  // Mostly well-formed frames with random content, so the later checks and the OK path
  // are reached; the rest break one check each, or are plain noise.
  task automatic send_random_frame();
    frame_kind_e kind;
    int body;
    int idx;
    logic [7:0] ty;
    kind = pick_kind();
    body = ($urandom_range(9) == 0) ? $urandom_range(128, 64) : $urandom_range(12);
    ty = (kind == FR_TYPE) ? pick_invalid_type() : pick_valid_type();
    build_frame(board.magic, board.version, ty, 16'(body), body, 1'b0, 8'h00);
    case (kind)
      FR_SHORT: begin
        idx = $urandom_range(HDR_LEN - 1, 1);
        while (frame_bytes.size() > idx) void'(frame_bytes.pop_back());
      end
      FR_MAGIC: frame_bytes[$urandom_range(1)] ^= 8'($urandom_range(255, 1));
      FR_VERSION: frame_bytes[VER_OFF] ^= 8'($urandom_range(255, 1));
      FR_LENGTH: begin
        if (body == 0 || $urandom_range(1) == 0) begin
          repeat ($urandom_range(3, 1)) frame_bytes.push_back(8'($urandom));
        end else begin
          repeat ($urandom_range(body < 3 ? body : 3, 1)) void'(frame_bytes.pop_back());
        end
      end
      FR_CRC: begin
        // Any byte covered by the CRC but by no earlier check, or the CRC field itself.
        do idx = $urandom_range(frame_bytes.size() - 1, FLAGS_OFF);
        while (idx == LEN_OFF || idx == LEN_OFF + 1);
        frame_bytes[idx] ^= 8'($urandom_range(255, 1));
      end
      FR_NOISE: begin
        frame_bytes.delete();
        repeat ($urandom_range(40, 1)) frame_bytes.push_back(8'($urandom));
      end
      default: ;
    endcase
    send_frame();
  endtask

  // One register setting per segment; the fixed ones cover the extremes and the defaults.
  // Upper data bits beyond a register's width are random and must be dropped.
  task automatic apply_setting(input int s);
    logic [15:0] mg;
    logic [7:0] ver;
    logic [63:0] tm;
    logic [63:0] filler;
    mg = 16'($urandom);
    ver = 8'($urandom);
    tm = {$urandom, $urandom};
    filler = {$urandom, $urandom};
    case (s)
      0: begin
        mg = '1;
        ver = '1;
        tm = '1;
      end
      1: begin
        ver = '0;
        tm = 64'd1 << (TYPE_CODES - 1);
      end
      2: begin
        mg = '0;
        tm = '0;
      end
      4: tm = 64'd1;
      5: begin
        mg = MAGIC_RST;
        ver = VERSION_RST;
        tm = TMASK_RST;
      end
      default: ;
    endcase
    write_reg(CFG_MAGIC, {filler[63:16], mg});
    write_reg(CFG_VERSION, {filler[63:8], ver});
    write_reg(CFG_TYPE_MASK, tm);
  endtask

  initial begin
    int target;
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames under the reset configuration. A lone closing byte and a 19-byte
    // frame are both too short.
    frame_bytes.delete();
    frame_bytes.push_back(8'hFF);
    send_frame();
    frame_bytes.delete();
    repeat (HDR_LEN - 1) frame_bytes.push_back(8'h00);
    send_frame();
    // Good frames with all-zero and all-ones header fields.
    build_frame(MAGIC_RST, VERSION_RST, 8'd0, 16'd0, 0, 1'b1, 8'h00);
    send_frame();
    build_frame(board.magic, board.version, 8'd6, 16'd3, 3, 1'b1, 8'hFF);
    send_frame();
    // Type 7 lies outside the reset mask.
    build_frame(board.magic, board.version, 8'd7, 16'd2, 2, 1'b0, 8'h00);
    send_frame();
    build_frame(board.magic ^ 16'h8001, board.version, 8'd1, 16'd0, 0, 1'b0, 8'h00);
    send_frame();
    build_frame(board.magic, board.version ^ 8'h80, 8'd1, 16'd0, 0, 1'b0, 8'h00);
    send_frame();
    // One byte more than the header announces.
    build_frame(board.magic, board.version, 8'd2, 16'd4, 4, 1'b0, 8'h00);
    frame_bytes.push_back(8'h5A);
    send_frame();
    build_frame(board.magic, board.version, 8'd3, 16'd1, 1, 1'b0, 8'h00);
    frame_bytes[CRC_OFF] ^= 8'h01;
    send_frame();

    // A write to the unused index must leave every register as it was.
    drain();
    write_reg(CFG_UNUSED, '1);
    build_frame(board.magic, board.version, 8'd5, 16'd2, 2, 1'b0, 8'h00);
    send_frame();

    // With every mask bit set, codes of 64 and above are still rejected.
    drain();
    write_reg(CFG_TYPE_MASK, '1);
    build_frame(board.magic, board.version, 8'd64, 16'd0, 0, 1'b0, 8'h00);
    send_frame();
    build_frame(board.magic, board.version, 8'd255, 16'd0, 0, 1'b0, 8'h00);
    send_frame();
    build_frame(board.magic, board.version, 8'd63, 16'd0, 0, 1'b0, 8'h00);
    send_frame();

    // Random segments. Idling: none, sender only, receiver only, then both lightly.
    for (int s = 0; s < SEGMENTS; s++) begin
      case (s / 2)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_idle_pct = 83;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 83;
        end
        default: begin
          send_idle_pct = 12;
          stall_pct = 12;
        end
      endcase
      drain();
      apply_setting(s);
      target = items_sent + ITEMS_PER_SEGMENT;
      while (items_sent < target) send_random_frame();
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (board.pending.size() != 0) begin
      board.report($sformatf("%0d predicted results never arrived", board.pending.size()));
    end
    if (board.errors == 0) begin
      $display("pdu_frame_checker_unit_test: clean");
    end else begin
      $display("pdu_frame_checker_unit_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/pfc_pkg.sv
rtl/core/pfc_cfg_regs.sv
rtl/core/pfc_frame_track.sv
rtl/core/pfc_result_stage.sv
rtl/core/pdu_frame_checker_unit.sv
rtl/core/pfc_checker.sv
test/pdu_frame_checker_unit_test.sv
